[rtl/sgsg_pkg.sv]
`timescale 1ns / 1ps
package sgsg_pkg;
    localparam int MAX_POINTS  = 4096;
    localparam int GRID_COLS   = 256;
    localparam int GRID_ROWS   = 256;
    localparam int EXP_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int EXP_W       = $clog2(EXP_ENTRIES);
    localparam int BAL_W       = CNT_W + 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_INV   = 3'd1;
    localparam logic [2:0] REG_OX    = 3'd2;
    localparam logic [2:0] REG_OY    = 3'd3;
    localparam logic [2:0] REG_SX    = 3'd4;
    localparam logic [2:0] REG_SY    = 3'd5;
    localparam logic [2:0] REG_FLOOR = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               point_negative;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
    } t_in;

    typedef struct packed {
        logic signed [39:0] density;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] data;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic take;      // register the request
        logic load;      // append point
        logic clear;     // empty store
        logic eval_init; // clear accumulator, form cell position
        logic issue;     // read store entry and push through pipe
        logic finish;    // saturate/floor and emit
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       last;     // issue index reached count
        logic       drained;  // pipe empty
    } t_stat;

    // long division by a small integer, shift and subtract
    function automatic longint unsigned div_small(input longint unsigned a,
                                                  input int unsigned d);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], a[b]};
            if (r >= longint'(d)) begin
                r = r - longint'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-16k/EXP_ENTRIES) in Q1.15
    function automatic logic [15:0] exp_entry(input int k);
        longint unsigned v, t, e;
        longint s;
        v = (longint'(k) << 29) >> EXP_W;
        t = 64'd1 << 30;
        s = 64'sd1 << 30;
        for (int n = 1; n <= 16; n++) begin
            t = div_small((t * v) >> 30, n);
            if (n[0]) s = s - longint'(t);
            else s = s + longint'(t);
        end
        if (s < 0) s = 0;
        e = s;
        for (int i = 0; i < 5; i++) e = (e * e + (64'd1 << 29)) >> 30;
        e = (e + (64'd1 << 14)) >> 15;
        if (e > 65535) e = 65535;
        return e[15:0];
    endfunction
endpackage

[rtl/signed_gaussian_splat_grid.sv]
`timescale 1ns / 1ps
// Signed Gaussian splat grid: kernel density of signed points at grid cells.
// Request channel: start with i_req; taken when start is high and busy low.
// Configuration: i_cfg_valid/o_cfg_ready with index and data, write while idle.
// Result: o_res on the cycle o_valid is high, one per request; the receiver
// cannot stall, so each result is shown for that single cycle only.
// Sequencing: load, clear and unknown operations pass the decode and finish
// states, and the result strobe is registered from finish; busy is already low
// in that strobe cycle. Evaluate passes decode and init, then the store memory
// is read one point per cycle through a seven-stage distance, exp table and
// gain pipeline into the accumulator, waits for the pipe to drain and finishes,
// so the point count sets the run length (up to 4096 points).
// Reset clears point count, sign balance and the registers to their defaults;
// stored points need no clearing, only entries below the count are read.
module signed_gaussian_splat_grid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sgsg_pkg::t_in   i_req,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  sgsg_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output sgsg_pkg::t_out  o_res
);
    sgsg_pkg::t_cmd  w_cmd;
    sgsg_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sgsg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    sgsg_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cfg(i_cfg),
        .i_cfg_we(i_cfg_valid), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_strobe(o_valid), .o_res(o_res)
    );
endmodule

[rtl/sgsg_ctrl.sv]
`timescale 1ns / 1ps
module sgsg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  sgsg_pkg::t_stat i_stat,
    output sgsg_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.take = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.op == sgsg_pkg::OP_EVAL) begin
                    n_state = S_INIT;
                end else begin
                    o_cmd.load  = (i_stat.op == sgsg_pkg::OP_LOAD) && !i_stat.full;
                    o_cmd.clear = (i_stat.op == sgsg_pkg::OP_CLEAR);
                    n_state = S_FIN;
                end
            end
            S_INIT: begin
                o_cmd.eval_init = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (i_stat.last) n_state = S_WAIT;
                else o_cmd.issue = 1'b1;
            end
            S_WAIT: begin
                if (i_stat.drained) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

[rtl/sgsg_datapath.sv]
`timescale 1ns / 1ps
module sgsg_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgsg_pkg::t_in   i_req,
    input  sgsg_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_we,
    input  sgsg_pkg::t_cmd  i_cmd,
    output sgsg_pkg::t_stat o_stat,
    output logic           o_strobe,
    output sgsg_pkg::t_out  o_res
);
    localparam int AW = sgsg_pkg::ADDR_W;
    localparam int CW = sgsg_pkg::CNT_W;
    localparam int EW = sgsg_pkg::EXP_W;

    logic [15:0] c_exp [sgsg_pkg::EXP_ENTRIES];
    always_comb begin
        for (int k = 0; k < sgsg_pkg::EXP_ENTRIES; k++) c_exp[k] = sgsg_pkg::exp_entry(k);
    end

    // configuration registers
    logic [23:0] r_gain;
    logic [15:0] r_inv, r_sx, r_sy, r_floor;
    logic signed [15:0] r_ox, r_oy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 24'd155629; r_inv <= 16'd2048; r_ox <= '0; r_oy <= '0;
            r_sx <= 16'd256; r_sy <= 16'd256; r_floor <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg.index[2:0] | {3{i_cfg.index[3]}})
                sgsg_pkg::REG_GAIN:  r_gain  <= i_cfg.data[23:0];
                sgsg_pkg::REG_INV:   r_inv   <= i_cfg.data[15:0];
                sgsg_pkg::REG_OX:    r_ox    <= i_cfg.data[15:0];
                sgsg_pkg::REG_OY:    r_oy    <= i_cfg.data[15:0];
                sgsg_pkg::REG_SX:    r_sx    <= i_cfg.data[15:0];
                sgsg_pkg::REG_SY:    r_sy    <= i_cfg.data[15:0];
                sgsg_pkg::REG_FLOOR: r_floor <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // request register, count and balance
    sgsg_pkg::t_in r_req;
    logic [CW-1:0] r_count;
    logic signed [sgsg_pkg::BAL_W-1:0] r_bal;
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_req <= i_req;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_bal   <= '0;
        end else if (i_cmd.load) begin
            r_count <= r_count + 1'b1;
            r_bal   <= r_req.point_negative ? r_bal - 1'b1 : r_bal + 1'b1;
        end
    end

    // point store
    logic [32:0] r_mem [sgsg_pkg::MAX_POINTS];
    logic [32:0] r_rd;
    logic [CW-1:0] r_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_mem[r_count[AW-1:0]] <= {r_req.point_x, r_req.point_y, r_req.point_negative};
        if (i_cmd.issue) r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // cell position and issue index
    logic signed [25:0] r_cx, r_cy;
    logic r_flip;
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_init) begin
            r_cx   <= 26'(r_ox) + 26'($signed({1'b0, 24'(r_req.cell_col) * 24'(r_sx)}));
            r_cy   <= 26'(r_oy) + 26'($signed({1'b0, 24'(r_req.cell_row) * 24'(r_sy)}));
            r_flip <= r_bal < 0;
            r_idx  <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // pipe: v1 read, v2 diffs, v3 squares, v4 d2, v5 u, v6 entry, v7 term, acc
    logic [6:1] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= {r_v[5:1], i_cmd.issue};
    end
    logic r_n2, r_n3, r_n4, r_n5, r_n6;
    logic [25:0] r_ax, r_ay;
    logic [51:0] r_sqx, r_sqy;
    logic [52:0] r_d2;
    logic [47:0] r_u;
    logic        r_ok5;
    logic [15:0] r_e;
    logic        r_ok6;
    logic [39:0] r_term;
    logic signed [26:0] w_dx, w_dy;
    assign w_dx = 27'(r_cx) - 27'($signed(r_rd[32:17]));
    assign w_dy = 27'(r_cy) - 27'($signed(r_rd[16:1]));
    always_ff @(posedge i_clk) begin
        r_ax  <= w_dx[26] ? 26'(-w_dx) : w_dx[25:0];
        r_ay  <= w_dy[26] ? 26'(-w_dy) : w_dy[25:0];
        r_n2  <= r_rd[0] != r_flip;
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
        r_n3  <= r_n2;
        r_d2  <= 53'(r_sqx) + 53'(r_sqy);
        r_n4  <= r_n3;
        r_ok5 <= (r_inv == 16'd0) || (r_d2[52:32] == '0);
        r_u   <= r_d2[31:0] * r_inv;
        r_n5  <= r_n4;
        r_ok6 <= r_ok5 && (r_u[47:32] == '0);
        r_e   <= c_exp[r_u[31:32-EW]];
        r_n6  <= r_n5;
        r_term <= 40'((41'(r_gain) * 41'(r_e) + 41'd16384) >> 15);
    end
    logic r_ok7, r_n7;
    always_ff @(posedge i_clk) begin
        r_ok7 <= r_ok6;
        r_n7  <= r_n6;
    end

    // accumulator
    logic r_v7;
    logic signed [53:0] r_acc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else r_v7 <= r_v[6];
        if (i_cmd.eval_init) r_acc <= '0;
        else if (r_v7 && r_ok7)
            r_acc <= r_n7 ? r_acc - 54'(r_term) : r_acc + 54'(r_term);
    end

    // finish: dropped status for loads, saturate and floor for evaluate
    logic signed [53:0] w_fl;
    logic r_load_done;
    sgsg_pkg::t_out w_out;
    assign w_fl = 54'(r_floor);
    always_comb begin
        w_out = '0;
        if (r_req.operation == sgsg_pkg::OP_LOAD && r_count == CW'(sgsg_pkg::MAX_POINTS)
            && !r_load_done)
            w_out.status = sgsg_pkg::ST_DROPPED;
        else if (r_req.operation == sgsg_pkg::OP_EVAL) begin
            if (r_acc > 54'sh7F_FFFF_FFFF) begin
                w_out.density = 40'sh7F_FFFF_FFFF; w_out.status = sgsg_pkg::ST_SAT;
            end else if (r_acc < -54'sh80_0000_0000) begin
                w_out.density = 40'sh80_0000_0000; w_out.status = sgsg_pkg::ST_SAT;
            end else if (r_acc >= 0 && r_acc < w_fl) w_out.density = w_fl[39:0];
            else if (r_acc < 0 && r_acc > -w_fl) w_out.density = 40'(-w_fl);
            else w_out.density = r_acc[39:0];
        end
    end
    // remembers whether this request's load went in
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_load_done <= 1'b0;
        else if (i_cmd.load) r_load_done <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= i_cmd.finish;
        if (i_cmd.finish) o_res <= w_out;
    end

    assign o_stat.op      = r_req.operation;
    assign o_stat.full    = r_count == CW'(sgsg_pkg::MAX_POINTS);
    assign o_stat.last    = r_idx == r_count;
    assign o_stat.drained = (r_v == '0) && !r_v7;
endmodule

[rtl/sgsg_checker.sv]
`timescale 1ns / 1ps
module sgsg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          i_valid,
    input sgsg_pkg::t_out i_res
);
    // a request makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not taken");
    // results only come out of a busy period
    a_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $past(busy)) else $error("result while idle");
    // strobe lasts one cycle
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid) else $error("strobe held");
    // status codes stay in range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_res.status <= sgsg_pkg::ST_SAT) else $error("bad status");
endmodule

bind signed_gaussian_splat_grid sgsg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_valid(o_valid), .i_res(o_res)
);
